// ===== design/aes256_pkg.sv =====
// Package with AES tables, round helpers and shared types.
`timescale 1ns / 1ps
package aes256_pkg;

  localparam int ROUNDS   = 14;
  localparam int RK_WORDS = 4 * (ROUNDS + 1);
  localparam int NK       = 8;

  typedef logic [7:0] byte_t;
  typedef logic [31:0] word_t;
  typedef logic [127:0] block_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_RUN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic dec;
  } cell_ctrl_t;

  localparam logic [0:255][7:0] SBOX = {
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
  };

  localparam logic [0:15][3:0] ROW_SHIFT = {
    4'd0, 4'd5, 4'd10, 4'd15, 4'd4, 4'd9, 4'd14, 4'd3,
    4'd8, 4'd13, 4'd2, 4'd7, 4'd12, 4'd1, 4'd6, 4'd11
  };

  function automatic byte_t inv_sbox(input byte_t x);
    byte_t r;
    r = 8'h00;
    for (int i = 0; i < 256; i++) begin
      if (SBOX[i] == x) r = byte_t'(i);
    end
    return r;
  endfunction

  function automatic byte_t xt(input byte_t x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic word_t sub_word(input word_t w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic byte_t get_b(input block_t s, input int i);
    return s[127 - 8 * i -: 8];
  endfunction

  function automatic block_t sub_shift(input block_t s, input logic inv);
    block_t o;
    o = '0;
    for (int i = 0; i < 16; i++) begin
      if (inv) o[127 - 8 * ROW_SHIFT[i] -: 8] = inv_sbox(get_b(s, i));
      else     o[127 - 8 * i -: 8] = SBOX[get_b(s, int'(ROW_SHIFT[i]))];
    end
    return o;
  endfunction

  function automatic block_t mix(input block_t s, input logic inv);
    block_t o;
    byte_t a0, a1, a2, a3, h, h1, h2, xh;
    o = s;
    for (int c = 0; c < 4; c++) begin
      a0 = get_b(s, 4 * c);
      a1 = get_b(s, 4 * c + 1);
      a2 = get_b(s, 4 * c + 2);
      a3 = get_b(s, 4 * c + 3);
      h = a0 ^ a1 ^ a2 ^ a3;
      h1 = h;
      h2 = h;
      xh = xt(h);
      if (inv) begin
        h1 = xt(xt(xh ^ a0 ^ a2)) ^ h;
        h2 = xt(xt(xh ^ a1 ^ a3)) ^ h;
      end
      o[127 - 32 * c -: 8]       = a0 ^ h1 ^ xt(a0 ^ a1);
      o[127 - 32 * c - 8 -: 8]  = a1 ^ h2 ^ xt(a1 ^ a2);
      o[127 - 32 * c - 16 -: 8] = a2 ^ h1 ^ xt(a2 ^ a3);
      o[127 - 32 * c - 24 -: 8] = a3 ^ h2 ^ xt(a3 ^ a0);
    end
    return o;
  endfunction

endpackage

// ===== design/aes256_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module aes256_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 60
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== design/aes256_key_cell.sv =====
// Key schedule cell: one of eight words in a sliding window of the key expansion.
`timescale 1ns / 1ps
module aes256_key_cell
  import aes256_pkg::*;
(
  input  logic  clk,
  input  logic  load,
  input  logic  shift,
  input  word_t load_word,
  input  word_t next_word,
  output word_t word_r
);
  word_t word_nxt;

  always_comb begin
    word_nxt = word_r;
    if (load)       word_nxt = load_word;
    else if (shift) word_nxt = next_word;
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end
endmodule

// ===== design/aes256_round_cell.sv =====
// Round cell: one column of the cipher state.
`timescale 1ns / 1ps
module aes256_round_cell
  import aes256_pkg::*;
(
  input  logic  clk,
  input  logic  load,
  input  logic  step,
  input  word_t load_word,
  input  word_t next_word,
  output word_t col_r
);
  word_t col_nxt;

  always_comb begin
    col_nxt = col_r;
    if (load)      col_nxt = load_word;
    else if (step) col_nxt = next_word;
  end

  always_ff @(posedge clk) begin
    col_r <= col_nxt;
  end
endmodule

// ===== design/aes256_block_cipher_core.sv =====
// AES-256 ECB core: key schedule chain, round key RAM and column cell row.
// After reset or any key write the first block waits while a chain of eight key cells
// expands the key, one round key word per cycle, into four 15-word RAMs. For each block
// the core first reads the first round key, then applies the initial key addition and
// the 14 rounds through a row of four column cells, reading one 128-bit round key per
// cycle, and then registers the result. A new block is accepted only once the previous
// result has been registered. The result stays in the output register until taken; the
// next block is accepted while it waits, but its rounds start only in the cycle after
// the held result is taken.
`timescale 1ns / 1ps
module aes256_block_cipher_core
  import aes256_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [63:0] in_block_high,
  input  logic [63:0] in_block_low,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_result_high,
  output logic [63:0] out_result_low
);
  localparam int RW = $clog2(ROUNDS + 1);

  logic [63:0] key_r [4];
  logic keys_ready_r, keys_ready_nxt;
  state_t state_r, state_nxt;
  logic [5:0] widx_r, widx_nxt;
  logic [3:0] rcnt_r, rcnt_nxt;
  logic [7:0] rcon_r, rcon_nxt;
  logic dec_r;
  logic pend_r, pend_nxt;
  logic [127:0] pend_blk_r;
  logic pend_cmd_r;
  logic ovalid_r, ovalid_nxt;
  logic [127:0] res_r;
  cell_ctrl_t ctrl;

  word_t kw [NK];
  word_t knew, t;
  logic kload, kshift;

  always_comb begin
    t = kw[NK-1];
    if (widx_r[2:0] == 3'd0) t = sub_word({t[23:0], t[31:24]}) ^ {rcon_r, 24'h0};
    else if (widx_r[2:0] == 3'd4) t = sub_word(t);
    knew = kw[0] ^ t;
  end

  genvar g;
  generate
    for (g = 0; g < NK; g++) begin : g_key
      aes256_key_cell u_kc (
        .clk(clk), .load(kload), .shift(kshift),
        .load_word((g % 2 == 1) ? key_r[g/2][31:0] : key_r[g/2][63:32]),
        .next_word((g == NK - 1) ? knew : kw[(g + 1) % NK]),
        .word_r(kw[g])
      );
    end
  endgenerate

  logic rk_we;
  logic [RW-1:0] rk_waddr, rk_raddr;
  word_t rk_wdata;
  word_t rk_col [4];

  always_comb begin
    rk_we = 1'b0;
    rk_waddr = widx_r[5:2];
    rk_wdata = knew;
    if (state_r == ST_EXPAND) begin
      rk_we = 1'b1;
      if (widx_r < 6'(NK)) rk_wdata = kw[widx_r[2:0]];
    end
  end

  word_t col [4];
  word_t col_nxt [4];
  logic [127:0] st, st_step;
  logic [127:0] rk;
  logic [127:0] in_blk;

  generate
    for (g = 0; g < 4; g++) begin : g_rk
      aes256_ram #(.WIDTH(32), .DEPTH(ROUNDS + 1)) u_ram (
        .clk(clk), .we(rk_we && (widx_r[1:0] == 2'(g))),
        .waddr(rk_waddr), .wdata(rk_wdata),
        .raddr(rk_raddr), .rdata(rk_col[g])
      );
    end
  endgenerate

  assign rk = {rk_col[0], rk_col[1], rk_col[2], rk_col[3]};
  assign st = {col[0], col[1], col[2], col[3]};
  assign in_blk = pend_blk_r;

  // rcnt steps through a block: 0 loads, 1..14 rounds, 15 done.
  always_comb begin
    if (!ctrl.dec) begin
      if (rcnt_r == 4'd0) st_step = in_blk ^ rk;
      else if (rcnt_r == 4'(ROUNDS)) st_step = sub_shift(st, 1'b0) ^ rk;
      else st_step = mix(sub_shift(st, 1'b0), 1'b0) ^ rk;
    end else begin
      if (rcnt_r == 4'd0) st_step = sub_shift(in_blk ^ rk, 1'b1);
      else if (rcnt_r == 4'(ROUNDS)) st_step = st ^ rk;
      else st_step = sub_shift(mix(st ^ rk, 1'b1), 1'b1);
    end
  end

  generate
    for (g = 0; g < 4; g++) begin : g_col
      assign col_nxt[g] = st_step[127 - 32 * g -: 32];
      aes256_round_cell u_rc (
        .clk(clk), .load(1'b0), .step(ctrl.start),
        .load_word(32'h0), .next_word(col_nxt[g]), .col_r(col[g])
      );
    end
  endgenerate

  always_comb begin
    logic [3:0] nr;
    nr = (state_r == ST_RUN) ? rcnt_r + 4'd1 : 4'd0;
    rk_raddr = (pend_nxt && state_r != ST_RUN) || state_r == ST_RUN
      ? ((pend_cmd_r && state_r == ST_RUN) || (state_r != ST_RUN && in_command && !pend_r)
         || (state_r != ST_RUN && pend_cmd_r && pend_r)
         ? RW'(4'(ROUNDS) - nr) : RW'(nr))
      : '0;
  end

  assign in_stall = pend_r;
  assign out_valid = ovalid_r;
  assign out_result_high = res_r[127:64];
  assign out_result_low = res_r[63:0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (pend_r && !keys_ready_r) state_nxt = ST_EXPAND;
        else if (pend_r && (!ovalid_r || !out_stall)) state_nxt = ST_RUN;
      end
      ST_EXPAND: if (widx_r == 6'(RK_WORDS - 1)) state_nxt = ST_IDLE;
      ST_RUN:    if (rcnt_r == 4'(ROUNDS)) state_nxt = ST_DONE;
      ST_DONE:   state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    kload = (state_r == ST_IDLE) && (state_nxt == ST_EXPAND);
    kshift = (state_r == ST_EXPAND) && (widx_r >= 6'(NK));
    ctrl.start = (state_r == ST_RUN);
    ctrl.dec = dec_r;
    widx_nxt = (state_r == ST_EXPAND) ? widx_r + 6'd1 : 6'd0;
    rcnt_nxt = (state_r == ST_RUN) ? rcnt_r + 4'd1 : 4'd0;
    rcon_nxt = rcon_r;
    if (kload) rcon_nxt = 8'h01;
    else if (state_r == ST_EXPAND && widx_r >= 6'(NK) && widx_r[2:0] == 3'd0)
      rcon_nxt = xt(rcon_r);
    keys_ready_nxt = keys_ready_r;
    if (state_r == ST_EXPAND && state_nxt == ST_IDLE) keys_ready_nxt = 1'b1;
    if (cfg_we) keys_ready_nxt = 1'b0;
    pend_nxt = pend_r;
    if (in_valid && !in_stall) pend_nxt = 1'b1;
    if (state_r == ST_DONE) pend_nxt = 1'b0;
    ovalid_nxt = ovalid_r;
    if (ovalid_r && !out_stall) ovalid_nxt = 1'b0;
    if (state_r == ST_DONE) ovalid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      keys_ready_r <= 1'b0;
      pend_r <= 1'b0;
      ovalid_r <= 1'b0;
      widx_r <= '0;
      rcnt_r <= '0;
      rcon_r <= 8'h01;
      for (int i = 0; i < 4; i++) key_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      keys_ready_r <= keys_ready_nxt;
      pend_r <= pend_nxt;
      ovalid_r <= ovalid_nxt;
      widx_r <= widx_nxt;
      rcnt_r <= rcnt_nxt;
      rcon_r <= rcon_nxt;
      if (cfg_we) key_r[cfg_index] <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      pend_blk_r <= {in_block_high, in_block_low};
      pend_cmd_r <= in_command;
    end
    if (state_r == ST_IDLE) dec_r <= pend_cmd_r;
    if (state_r == ST_DONE) res_r <= st;
  end
endmodule
